[sv/atb_pkg.sv]
// ----------------------------------------------------------------------------
// atb_pkg
// Shared types, constants and helper functions of the ANSI text terminal
// cell buffer.
// ----------------------------------------------------------------------------
package atb_pkg;

    localparam int COLUMNS_DEF      = 80;
    localparam int VISIBLE_ROWS_DEF = 25;
    localparam int STORED_LINES_DEF = 128;
    localparam int MAX_PARAMS_DEF   = 8;

    // widest cell address over the legal parameter range (256 x 1024 cells)
    localparam int RAM_AW_MAX = 18;

    localparam logic [7:0] RESET_BLANK = 8'd15;

    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_ESC    = 8'd27;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_R      = 8'h52;

    localparam logic [7:0] FB_CUU = 8'h41;
    localparam logic [7:0] FB_CUD = 8'h42;
    localparam logic [7:0] FB_CUF = 8'h43;
    localparam logic [7:0] FB_CUB = 8'h44;
    localparam logic [7:0] FB_CUP = 8'h48;
    localparam logic [7:0] FB_ED  = 8'h4A;
    localparam logic [7:0] FB_EL  = 8'h4B;
    localparam logic [7:0] FB_HVP = 8'h66;
    localparam logic [7:0] FB_SGR = 8'h6D;
    localparam logic [7:0] FB_DSR = 8'h6E;

    localparam logic [2:0] DEC_LAST = 3'd4;

    typedef struct packed {
        logic        op;
        logic [7:0]  char_code;
        logic [7:0]  color;
        logic [13:0] cell_address;
    } t_in_item;

    typedef struct packed {
        logic        response_valid;
        logic [7:0]  response_byte;
        logic [15:0] cell_data;
        logic [15:0] cursor_col;
        logic [15:0] cursor_row;
        logic [6:0]  view_top;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic                  we;
        logic [RAM_AW_MAX-1:0] waddr;
        logic [15:0]           wdata;
        logic                  re;
        logic [RAM_AW_MAX-1:0] raddr;
    } t_ram_req;

    function automatic logic [2:0] ansi_base(input logic [2:0] idx);
        ansi_base = {idx[0], idx[1], idx[2]};
    endfunction

    function automatic logic [16:0] dec_thr(input logic [2:0] dec, input int k);
        unique case (dec)
            3'd0:    dec_thr = 17'(k * 10000);
            3'd1:    dec_thr = 17'(k * 1000);
            3'd2:    dec_thr = 17'(k * 100);
            3'd3:    dec_thr = 17'(k * 10);
            default: dec_thr = 17'(k);
        endcase
    endfunction

endpackage

[sv/atb_stream_if.sv]
// ----------------------------------------------------------------------------
// atb_stream_if
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface atb_stream_if #(
    parameter type T_DATA = logic
);
    logic  valid;
    logic  ready;
    T_DATA data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[sv/atb_cell_ram.sv]
// ----------------------------------------------------------------------------
// atb_cell_ram
// Single-port-write, single-port-read cell store with registered read data.
// ----------------------------------------------------------------------------
module atb_cell_ram
    import atb_pkg::*;
#(
    parameter int DEPTH = COLUMNS_DEF * STORED_LINES_DEF
) (
    input  logic        i_clk,
    input  t_ram_req    i_req,
    output logic [15:0] o_rdata
);
    localparam int AW = $clog2(DEPTH);

    logic [15:0] mem [DEPTH];
    logic [15:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr[AW-1:0]] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= mem[i_req.raddr[AW-1:0]];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[sv/atb_ctrl.sv]
// ----------------------------------------------------------------------------
// atb_ctrl
// Sequencer: escape parser, cursor and view state, store walks and the
// result register.
// ----------------------------------------------------------------------------
module atb_ctrl
    import atb_pkg::*;
#(
    parameter int COLUMNS      = COLUMNS_DEF,
    parameter int VISIBLE_ROWS = VISIBLE_ROWS_DEF,
    parameter int STORED_LINES = STORED_LINES_DEF,
    parameter int MAX_PARAMS   = MAX_PARAMS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    atb_stream_if.sink    i_in,
    atb_stream_if.source  o_out,
    input  logic [7:0]    i_blank,
    output t_ram_req      o_ram,
    input  logic [15:0]   i_rdata
);
    localparam int SIZE = COLUMNS * STORED_LINES;
    localparam int AW   = $clog2(SIZE);
    localparam int EW   = AW + 1;
    localparam int PW   = 16 + $clog2(COLUMNS + 1) + 1;
    localparam int VTW  = $clog2(STORED_LINES);
    localparam int PIW  = $clog2(MAX_PARAMS);
    localparam int PCW  = $clog2(MAX_PARAMS + 1);
    localparam logic [15:0] SAT = 16'hFFFF;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_READ, S_MUL, S_WR, S_KADDR, S_FIX, S_SCROLL,
        S_MVLAST, S_FILL, S_POST, S_DISP, S_SGR, S_REP, S_EMIT
    } t_state;

    typedef enum logic [1:0] {PH_TEXT, PH_ESC, PH_CSI} t_phase;

    t_state          r_state;
    t_state          r_ret;
    t_phase          r_phase;
    logic [AW-1:0]   r_ptr;
    logic [EW-1:0]   r_end;
    logic [15:0]     r_fill_val;
    logic [15:0]     r_col;
    logic [15:0]     r_row;
    logic [VTW-1:0]  r_vt;
    logic [7:0]      r_cur;
    logic [15:0]     r_par [MAX_PARAMS];
    logic [PCW-1:0]  r_cnt;
    logic [7:0]      r_ch;
    logic [7:0]      r_attr;
    logic            r_second;
    logic            r_glyph;
    logic            r_kmode;
    logic [15:0]     r_wval;
    logic [PW-1:0]   r_prod;
    logic [15:0]     r_cell;
    logic            r_rok;
    logic            r_mv_pend;
    logic [AW-1:0]   r_mv_addr;
    logic [PIW-1:0]  r_sgr_i;
    logic [2:0]      r_rsub;
    logic [2:0]      r_dec;
    logic [16:0]     r_dval;
    logic [16:0]     r_xval;
    logic            r_started;
    logic            r_ov;
    t_out_item       r_od;

    logic            accept;
    logic            free;
    logic [PW-1:0]   wsum;
    logic [PW-1:0]   kend;
    logic [PW-1:0]   kendc;
    logic            col_wrap;
    logic [15:0]     fcol;
    logic [15:0]     frow;
    logic [PIW-1:0]  s_idx;
    logic [PIW-1:0]  p_idx;
    logic [15:0]     p_sel;
    logic [15:0]     p0;
    logic [15:0]     nmov;
    logic [3:0]      dig;
    logic [16:0]     dig_sub;
    logic [7:0]      attr_in;
    logic [PCW-1:0]  cnt_inc;
    logic [19:0]     pmul;
    logic [16:0]     tab_sum;
    logic [16:0]     ysum;
    logic [15:0]     vt16;

    assign accept    = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign free      = !r_ov || o_out.ready;
    assign o_out.valid = r_ov;
    assign o_out.data  = r_od;

    assign wsum  = r_prod + PW'(r_col);
    assign kend  = r_prod + PW'(COLUMNS);
    assign kendc = (kend < PW'(SIZE)) ? kend : PW'(SIZE);
    assign col_wrap = (r_col >= 16'(COLUMNS));
    assign fcol = col_wrap ? 16'd0 : r_col;
    assign frow = col_wrap ? ((r_row == SAT) ? SAT : r_row + 16'd1) : r_row;
    assign s_idx = (r_cnt < PCW'(MAX_PARAMS)) ? PIW'(r_cnt) : PIW'(MAX_PARAMS - 1);
    assign p_idx = (r_state == S_SGR) ? r_sgr_i : s_idx;
    assign p_sel = r_par[p_idx];
    assign p0    = r_par[0];
    assign nmov  = (p0 != 16'd0) ? p0 : 16'd1;
    assign attr_in = (i_in.data.color == 8'd0) ? r_cur : i_in.data.color;
    assign cnt_inc = (r_cnt < PCW'(MAX_PARAMS)) ? r_cnt + PCW'(1) : r_cnt;
    assign pmul  = 20'(p_sel) * 20'd10 + 20'(i_in.data.char_code - CH_ZERO);
    assign tab_sum = (17'(r_col) + 17'd8) & ~17'd7;
    assign vt16  = 16'(r_vt);
    assign ysum  = {1'b0, vt16} + 17'((p0 != 16'd0) ? p0 - 16'd1 : 16'd0);

    always_comb begin
        dig     = 4'd0;
        dig_sub = 17'd0;
        for (int k = 1; k <= 9; k++) begin
            if (r_dval >= dec_thr(r_dec, k)) begin
                dig     = 4'(k);
                dig_sub = dec_thr(r_dec, k);
            end
        end
    end

    always_comb begin
        o_ram = '0;
        priority if (r_mv_pend) begin
            o_ram.we    = 1'b1;
            o_ram.waddr = RAM_AW_MAX'(r_mv_addr);
            o_ram.wdata = i_rdata;
        end else if (r_state == S_INIT) begin
            o_ram.we    = 1'b1;
            o_ram.waddr = RAM_AW_MAX'(r_ptr);
            o_ram.wdata = {RESET_BLANK, CH_SPACE};
        end else if (r_state == S_FILL) begin
            o_ram.we    = 1'b1;
            o_ram.waddr = RAM_AW_MAX'(r_ptr);
            o_ram.wdata = r_fill_val;
        end else if (r_state == S_WR) begin
            o_ram.we    = (wsum < PW'(SIZE));
            o_ram.waddr = RAM_AW_MAX'(wsum);
            o_ram.wdata = r_wval;
        end else begin
            o_ram.we = 1'b0;
        end
        if (r_state == S_SCROLL) begin
            o_ram.re    = 1'b1;
            o_ram.raddr = RAM_AW_MAX'(r_ptr) + RAM_AW_MAX'(COLUMNS);
        end else if (accept && i_in.data.op == OP_READ) begin
            o_ram.re    = 1'b1;
            o_ram.raddr = RAM_AW_MAX'(i_in.data.cell_address);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_INIT;
            r_ptr     <= '0;
            r_phase   <= PH_TEXT;
            r_col     <= '0;
            r_row     <= '0;
            r_vt      <= '0;
            r_cur     <= RESET_BLANK;
            r_cnt     <= '0;
            r_second  <= 1'b0;
            r_mv_pend <= 1'b0;
            r_ov      <= 1'b0;
            for (int i = 0; i < MAX_PARAMS; i++) begin
                r_par[i] <= '0;
            end
        end else begin
            r_mv_pend <= 1'b0;
            if (r_ov && o_out.ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_INIT: begin
                    if (r_ptr == AW'(SIZE - 1)) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_ptr <= r_ptr + AW'(1);
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_cell <= '0;
                        r_ch   <= i_in.data.char_code;
                        r_attr <= attr_in;
                        if (i_in.data.op == OP_READ) begin
                            r_rok   <= (32'(i_in.data.cell_address) < 32'(SIZE));
                            r_state <= S_READ;
                        end else begin
                            unique case (r_phase)
                                PH_ESC: begin
                                    if (i_in.data.char_code == CH_LBRACK) begin
                                        r_phase <= PH_CSI;
                                        r_cnt   <= '0;
                                        for (int i = 0; i < MAX_PARAMS; i++) begin
                                            r_par[i] <= '0;
                                        end
                                    end else begin
                                        r_phase <= PH_TEXT;
                                    end
                                    r_state <= S_EMIT;
                                end
                                PH_CSI: begin
                                    if (i_in.data.char_code >= CH_ZERO &&
                                        i_in.data.char_code <= CH_NINE) begin
                                        r_par[s_idx] <= (pmul > 20'(SAT)) ? SAT : pmul[15:0];
                                        r_state <= S_EMIT;
                                    end else if (i_in.data.char_code == CH_SEMI) begin
                                        if (r_cnt < PCW'(MAX_PARAMS - 1)) begin
                                            r_cnt <= r_cnt + PCW'(1);
                                            r_par[PIW'(r_cnt + PCW'(1))] <= '0;
                                        end else begin
                                            r_par[PIW'(MAX_PARAMS - 1)] <= '0;
                                        end
                                        r_state <= S_EMIT;
                                    end else if (i_in.data.char_code == CH_QMARK) begin
                                        r_state <= S_EMIT;
                                    end else begin
                                        r_state <= S_DISP;
                                    end
                                end
                                default: begin
                                    r_phase <= PH_TEXT;
                                    r_kmode <= 1'b0;
                                    r_second <= 1'b0;
                                    if (i_in.data.char_code == CH_ESC) begin
                                        r_phase <= PH_ESC;
                                        r_state <= S_EMIT;
                                    end else if (i_in.data.char_code == CH_NL) begin
                                        r_col   <= '0;
                                        r_row   <= (r_row == SAT) ? SAT : r_row + 16'd1;
                                        r_state <= S_FIX;
                                    end else if (i_in.data.char_code == CH_CR) begin
                                        r_col   <= '0;
                                        r_state <= S_FIX;
                                    end else if (i_in.data.char_code == CH_BS) begin
                                        if (r_col != 16'd0) begin
                                            r_col <= r_col - 16'd1;
                                        end else if (r_row != 16'd0) begin
                                            r_row <= r_row - 16'd1;
                                            r_col <= 16'(COLUMNS - 1);
                                        end
                                        r_wval  <= {attr_in, CH_SPACE};
                                        r_glyph <= 1'b0;
                                        r_state <= S_MUL;
                                    end else if (i_in.data.char_code == CH_TAB) begin
                                        r_col   <= tab_sum[16] ? SAT : tab_sum[15:0];
                                        r_state <= S_FIX;
                                    end else if (i_in.data.char_code < CH_SPACE) begin
                                        r_wval   <= {attr_in, CH_CARET};
                                        r_glyph  <= 1'b1;
                                        r_second <= 1'b1;
                                        r_state  <= S_MUL;
                                    end else begin
                                        r_wval  <= {attr_in, i_in.data.char_code};
                                        r_glyph <= 1'b1;
                                        r_state <= S_MUL;
                                    end
                                end
                            endcase
                        end
                    end
                end
                S_READ: begin
                    r_cell  <= r_rok ? i_rdata : 16'd0;
                    r_state <= S_EMIT;
                end
                S_MUL: begin
                    r_prod  <= PW'(r_row) * PW'(COLUMNS);
                    r_state <= r_kmode ? S_KADDR : S_WR;
                end
                S_WR: begin
                    if (r_glyph) begin
                        r_col <= (r_col == SAT) ? SAT : r_col + 16'd1;
                    end
                    r_state <= S_FIX;
                end
                S_KADDR: begin
                    if (wsum < kendc) begin
                        r_ptr      <= AW'(wsum);
                        r_end      <= EW'(kendc);
                        r_fill_val <= {r_cur, CH_SPACE};
                        r_ret      <= S_EMIT;
                        r_state    <= S_FILL;
                    end else begin
                        r_state <= S_EMIT;
                    end
                end
                S_FIX: begin
                    r_col <= fcol;
                    if (frow >= 16'(STORED_LINES)) begin
                        r_row   <= 16'(STORED_LINES - 1);
                        r_ptr   <= '0;
                        r_state <= S_SCROLL;
                    end else begin
                        r_row   <= frow;
                        r_state <= S_POST;
                    end
                end
                S_SCROLL: begin
                    r_mv_pend <= 1'b1;
                    r_mv_addr <= r_ptr;
                    if (r_ptr == AW'(SIZE - COLUMNS - 1)) begin
                        r_state <= S_MVLAST;
                    end else begin
                        r_ptr <= r_ptr + AW'(1);
                    end
                end
                S_MVLAST: begin
                    r_ptr      <= AW'(SIZE - COLUMNS);
                    r_end      <= EW'(SIZE);
                    r_fill_val <= {i_blank, CH_SPACE};
                    r_ret      <= S_POST;
                    r_state    <= S_FILL;
                end
                S_FILL: begin
                    if (EW'(r_ptr) + EW'(1) == r_end) begin
                        r_state <= r_ret;
                    end else begin
                        r_ptr <= r_ptr + AW'(1);
                    end
                end
                S_POST: begin
                    r_vt <= (r_row > 16'(VISIBLE_ROWS - 1)) ?
                            VTW'(r_row - 16'(VISIBLE_ROWS - 1)) : '0;
                    if (r_second) begin
                        r_second <= 1'b0;
                        r_wval   <= {r_attr, r_ch + CH_AT};
                        r_glyph  <= 1'b1;
                        r_state  <= S_MUL;
                    end else begin
                        r_state <= S_EMIT;
                    end
                end
                S_DISP: begin
                    r_cnt   <= cnt_inc;
                    r_phase <= PH_TEXT;
                    r_state <= S_EMIT;
                    if (r_ch == FB_SGR) begin
                        r_sgr_i <= '0;
                        r_state <= S_SGR;
                    end else if (r_ch == FB_CUP || r_ch == FB_HVP) begin
                        r_row <= ysum[16] ? SAT : ysum[15:0];
                        r_col <= (cnt_inc >= PCW'(2) && r_par[1] != 16'd0) ?
                                 r_par[1] - 16'd1 : 16'd0;
                    end else if (r_ch == FB_CUU) begin
                        r_row <= (r_row > nmov) ? r_row - nmov : 16'd0;
                    end else if (r_ch == FB_CUD) begin
                        r_row <= ((17'(r_row) + 17'(nmov)) > 17'(SAT)) ? SAT : r_row + nmov;
                    end else if (r_ch == FB_CUF) begin
                        r_col <= ((17'(r_col) + 17'(nmov)) >= 17'(COLUMNS)) ?
                                 16'(COLUMNS - 1) : r_col + nmov;
                    end else if (r_ch == FB_CUB) begin
                        r_col <= (r_col > nmov) ? r_col - nmov : 16'd0;
                    end else if (r_ch == FB_ED) begin
                        if (p0 == 16'd2) begin
                            r_col      <= '0;
                            r_row      <= '0;
                            r_vt       <= '0;
                            r_ptr      <= '0;
                            r_end      <= EW'(SIZE);
                            r_fill_val <= {i_blank, CH_SPACE};
                            r_ret      <= S_EMIT;
                            r_state    <= S_FILL;
                        end
                    end else if (r_ch == FB_EL) begin
                        r_kmode <= 1'b1;
                        r_state <= S_MUL;
                    end else if (r_ch == FB_DSR) begin
                        if (p0 == 16'd6) begin
                            r_dval    <= (r_row >= vt16) ? 17'(r_row - vt16) + 17'd1 : 17'd1;
                            r_xval    <= 17'(r_col) + 17'd1;
                            r_rsub    <= 3'd0;
                            r_dec     <= 3'd0;
                            r_started <= 1'b0;
                            r_state   <= S_REP;
                        end
                    end
                end
                S_SGR: begin
                    if (p_sel == 16'd0) begin
                        r_cur <= i_blank;
                    end else if (p_sel >= 16'd30 && p_sel <= 16'd37) begin
                        r_cur <= {r_cur[7:4], 1'b0, ansi_base(3'(p_sel - 16'd30))};
                    end else if (p_sel >= 16'd40 && p_sel <= 16'd47) begin
                        r_cur <= {1'b0, ansi_base(3'(p_sel - 16'd40)), r_cur[3:0]};
                    end else if (p_sel >= 16'd90 && p_sel <= 16'd97) begin
                        r_cur <= {r_cur[7:4], 1'b1, ansi_base(3'(p_sel - 16'd90))};
                    end else if (p_sel >= 16'd100 && p_sel <= 16'd107) begin
                        r_cur <= {1'b1, ansi_base(3'(p_sel - 16'd100)), r_cur[3:0]};
                    end
                    if (PCW'(r_sgr_i) + PCW'(1) == r_cnt) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_sgr_i <= r_sgr_i + PIW'(1);
                    end
                end
                S_REP: begin
                    if (free) begin
                        r_od.response_valid <= 1'b1;
                        r_od.cell_data      <= '0;
                        r_od.cursor_col     <= r_col;
                        r_od.cursor_row     <= r_row;
                        r_od.view_top       <= 7'(r_vt);
                        r_od.last           <= 1'b0;
                        unique case (r_rsub)
                            3'd0: begin
                                r_od.response_byte <= CH_ESC;
                                r_ov   <= 1'b1;
                                r_rsub <= 3'd1;
                            end
                            3'd1: begin
                                r_od.response_byte <= CH_LBRACK;
                                r_ov   <= 1'b1;
                                r_rsub <= 3'd2;
                            end
                            3'd2, 3'd4: begin
                                if (dig != 4'd0 || r_started || r_dec == DEC_LAST) begin
                                    r_od.response_byte <= CH_ZERO + 8'(dig);
                                    r_ov      <= 1'b1;
                                    r_started <= 1'b1;
                                end
                                r_dval <= r_dval - dig_sub;
                                r_dec  <= r_dec + 3'd1;
                                if (r_dec == DEC_LAST) begin
                                    r_rsub    <= r_rsub + 3'd1;
                                    r_dval    <= r_xval;
                                    r_dec     <= 3'd0;
                                    r_started <= 1'b0;
                                end
                            end
                            3'd3: begin
                                r_od.response_byte <= CH_SEMI;
                                r_ov   <= 1'b1;
                                r_rsub <= 3'd4;
                            end
                            default: begin
                                r_od.response_byte <= CH_R;
                                r_od.last <= 1'b1;
                                r_ov      <= 1'b1;
                                r_state   <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_EMIT: begin
                    if (free) begin
                        r_od.response_valid <= 1'b0;
                        r_od.response_byte  <= '0;
                        r_od.cell_data      <= r_cell;
                        r_od.cursor_col     <= r_col;
                        r_od.cursor_row     <= r_row;
                        r_od.view_top       <= 7'(r_vt);
                        r_od.last           <= 1'b1;
                        r_ov    <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

[sv/ansi_text_terminal_buffer.sv]
// ----------------------------------------------------------------------------
// ansi_text_terminal_buffer
// ANSI text terminal cell buffer with escape parser and cursor report.
// ----------------------------------------------------------------------------
// After reset the block sweeps every cell of the store, one per cycle,
// before it takes the first item; configuration writes are taken
// throughout. A cell read passes the read and emit states, a parser byte
// the emit state, a printed character store address multiply, write, wrap
// and view update, a control echo those steps twice. The cell store has a
// single write port, which sets the cost of long operations: a scroll
// moves every cell up one line and blanks the last; clear screen blanks
// every cell, erase to end of line one cell per cycle, SGR one parameter
// per cycle, a status report one byte or decade per cycle while the output
// can take it. The next item is taken while the last result waits to transfer.
module ansi_text_terminal_buffer
    import atb_pkg::*;
#(
    parameter int COLUMNS      = COLUMNS_DEF,
    parameter int VISIBLE_ROWS = VISIBLE_ROWS_DEF,
    parameter int STORED_LINES = STORED_LINES_DEF,
    parameter int MAX_PARAMS   = MAX_PARAMS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    atb_stream_if.sink   i_in,
    atb_stream_if.source o_out,
    atb_stream_if.sink   i_cfg
);
    logic [7:0]  r_blank;
    t_ram_req    ram_req;
    logic [15:0] ram_rdata;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blank <= RESET_BLANK;
        end else if (i_cfg.valid) begin
            r_blank <= 8'(i_cfg.data);
        end
    end

    atb_ctrl #(
        .COLUMNS      (COLUMNS),
        .VISIBLE_ROWS (VISIBLE_ROWS),
        .STORED_LINES (STORED_LINES),
        .MAX_PARAMS   (MAX_PARAMS)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_out   (o_out),
        .i_blank (r_blank),
        .o_ram   (ram_req),
        .i_rdata (ram_rdata)
    );

    atb_cell_ram #(
        .DEPTH (COLUMNS * STORED_LINES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (ram_rdata)
    );
endmodule

[bench/atb_terminal_checker.sv]
// ----------------------------------------------------------------------------
// atb_terminal_checker
// Watches the input, output and configuration channels of the terminal
// buffer. Keeps its own copy of the cell store, cursor, view and escape
// parser, predicts the result items of every accepted input transfer and
// compares each output transfer field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module atb_terminal_checker
    import atb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_item  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_item i_out_data,
    input  logic      i_cfg_valid,
    input  logic      i_cfg_ready,
    input  logic [7:0] i_cfg_data,
    output int        o_pending,
    output int        o_errors
);

    localparam int COLS  = COLUMNS_DEF;
    localparam int VROWS = VISIBLE_ROWS_DEF;
    localparam int LINES = STORED_LINES_DEF;
    localparam int NPAR  = MAX_PARAMS_DEF;
    localparam int STORE = COLS * LINES;

    localparam int P_TEXT = 0;
    localparam int P_ESC  = 1;
    localparam int P_CSI  = 2;

    localparam logic [3:0] BASE_CLR [8] = '{4'd0, 4'd4, 4'd2, 4'd6, 4'd1, 4'd5, 4'd3, 4'd7};

    logic [15:0]  cells [STORE];
    int unsigned  ccol, crow, vtop, cbot;
    logic [7:0]   blank, cur;
    int           phase;
    int unsigned  pv [NPAR];
    int unsigned  pc;
    logic [7:0]   report_bytes [$];
    t_out_item    expected_q [$];

    assign o_pending = expected_q.size();

    function automatic int unsigned sat16(int unsigned v);
        return (v > 65535) ? 65535 : v;
    endfunction

    function automatic logic [15:0] blank_of(logic [7:0] a);
        return {a, CH_SPACE};
    endfunction

    task automatic reset_terminal();
        int i;
        blank = RESET_BLANK;
        for (i = 0; i < STORE; i++) cells[i] = blank_of(blank);
        ccol = 0; crow = 0; vtop = 0; cbot = 0;
        cur = blank;
        phase = P_TEXT;
        for (i = 0; i < NPAR; i++) pv[i] = 0;
        pc = 0;
        expected_q.delete();
    endtask

    task automatic poke(int unsigned a, logic [15:0] v);
        if (a < STORE) cells[a] = v;
    endtask

    task automatic settle();
        int i;
        if (ccol >= COLS) begin
            ccol = 0;
            crow = sat16(crow + 1);
        end
        if (crow >= LINES) begin
            for (i = 0; i < STORE - COLS; i++) cells[i] = cells[i + COLS];
            for (i = STORE - COLS; i < STORE; i++) cells[i] = blank_of(blank);
            crow = LINES - 1;
            cbot = LINES - 1;
        end
        if (crow > cbot) cbot = crow;
        vtop = (crow > VROWS - 1) ? crow - (VROWS - 1) : 0;
    endtask

    task automatic draw(logic [7:0] c, logic [7:0] a);
        poke(crow * COLS + ccol, {a, c});
        ccol = sat16(ccol + 1);
        settle();
    endtask

    task automatic text_byte(logic [7:0] c, logic [7:0] a);
        if (c == CH_NL) begin
            ccol = 0;
            crow = sat16(crow + 1);
        end else if (c == CH_CR) begin
            ccol = 0;
        end else if (c == CH_BS) begin
            if (ccol > 0) ccol--;
            else if (crow > 0) begin
                crow--;
                ccol = COLS - 1;
            end
            poke(crow * COLS + ccol, blank_of(a));
        end else if (c == CH_TAB) begin
            ccol = sat16((ccol + 8) & ~32'd7);
        end else if (c < CH_SPACE) begin
            draw(CH_CARET, a);
            draw(c + CH_AT, a);
            return;
        end else begin
            draw(c, a);
            return;
        end
        settle();
    endtask

    task automatic apply_sgr();
        int unsigned i, p;
        for (i = 0; i < pc && i < NPAR; i++) begin
            p = pv[i];
            if (p == 0) cur = blank;
            else if (p >= 30 && p <= 37) cur = {cur[7:4], BASE_CLR[p - 30]};
            else if (p >= 40 && p <= 47) cur = {BASE_CLR[p - 40], cur[3:0]};
            else if (p >= 90 && p <= 97) cur = {cur[7:4], BASE_CLR[p - 90] | 4'd8};
            else if (p >= 100 && p <= 107) cur = {BASE_CLR[p - 100] | 4'd8, cur[3:0]};
        end
    endtask

    task automatic push_decimal(int unsigned v);
        string s;
        int i;
        s = $sformatf("%0d", v);
        for (i = 0; i < s.len(); i++) report_bytes.push_back(s[i]);
    endtask

    task automatic run_final(logic [7:0] c);
        int unsigned p0, n, i, base, y;
        p0 = pv[0];
        n = (p0 > 0) ? p0 : 1;
        if (pc < NPAR) pc++;
        phase = P_TEXT;
        case (c)
            FB_SGR: apply_sgr();
            FB_CUP, FB_HVP: begin
                crow = sat16(vtop + ((pc >= 1 && p0 > 0) ? p0 - 1 : 0));
                ccol = (pc >= 2 && pv[1] > 0) ? pv[1] - 1 : 0;
            end
            FB_CUU: crow = (crow > n) ? crow - n : 0;
            FB_CUD: crow = sat16(crow + n);
            FB_CUF: begin
                ccol = ccol + n;
                if (ccol >= COLS) ccol = COLS - 1;
            end
            FB_CUB: ccol = (ccol > n) ? ccol - n : 0;
            FB_ED: begin
                if (p0 == 2) begin
                    for (i = 0; i < STORE; i++) cells[i] = blank_of(blank);
                    ccol = 0; crow = 0; vtop = 0; cbot = 0;
                end
            end
            FB_EL: begin
                base = crow * COLS;
                for (i = base + ccol; i < base + COLS && i < STORE; i++)
                    cells[i] = blank_of(cur);
            end
            FB_DSR: begin
                if (p0 == 6) begin
                    y = (crow >= vtop) ? crow - vtop + 1 : 1;
                    report_bytes.push_back(CH_ESC);
                    report_bytes.push_back(CH_LBRACK);
                    push_decimal(y);
                    report_bytes.push_back(CH_SEMI);
                    push_decimal(ccol + 1);
                    report_bytes.push_back(CH_R);
                end
            end
            default: ;
        endcase
    endtask

    task automatic feed_byte(logic [7:0] c, logic [7:0] attr_in);
        logic [7:0] a;
        int unsigned s, i;
        a = (attr_in == 0) ? cur : attr_in;
        if (phase == P_ESC) begin
            if (c == CH_LBRACK) begin
                phase = P_CSI;
                pc = 0;
                for (i = 0; i < NPAR; i++) pv[i] = 0;
            end else begin
                phase = P_TEXT;
            end
            return;
        end
        if (phase == P_CSI) begin
            s = (pc < NPAR) ? pc : NPAR - 1;
            if (c >= CH_ZERO && c <= CH_NINE) begin
                pv[s] = sat16(pv[s] * 10 + (c - CH_ZERO));
                return;
            end
            if (c == CH_SEMI) begin
                if (pc < NPAR - 1) pc++;
                s = (pc < NPAR) ? pc : NPAR - 1;
                pv[s] = 0;
                return;
            end
            if (c == CH_QMARK) return;
            run_final(c);
            return;
        end
        phase = P_TEXT;
        if (c == CH_ESC) begin
            phase = P_ESC;
            return;
        end
        text_byte(c, a);
    endtask

    function automatic t_out_item make_result(logic v, logic [7:0] b, logic [15:0] cdata,
                                              logic lst);
        t_out_item e;
        e.response_valid = v;
        e.response_byte  = b;
        e.cell_data      = cdata;
        e.cursor_col     = ccol[15:0];
        e.cursor_row     = crow[15:0];
        e.view_top       = vtop[6:0];
        e.last           = lst;
        return e;
    endfunction

    task automatic predict(t_in_item it);
        int i;
        report_bytes.delete();
        if (it.op == OP_READ) begin
            expected_q.push_back(make_result(1'b0, 8'd0,
                (it.cell_address < STORE) ? cells[it.cell_address] : 16'd0, 1'b1));
        end else begin
            feed_byte(it.char_code, it.color);
            if (report_bytes.size() == 0)
                expected_q.push_back(make_result(1'b0, 8'd0, 16'd0, 1'b1));
            else
                for (i = 0; i < report_bytes.size(); i++)
                    expected_q.push_back(make_result(1'b1, report_bytes[i], 16'd0,
                                                     i == report_bytes.size() - 1));
        end
    endtask

    task automatic report_mismatch(string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        o_errors++;
    endtask

    task automatic check_field(string name, int unsigned got, int unsigned want);
        if (got != want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    task automatic compare(t_out_item got);
        t_out_item e;
        if (expected_q.size() == 0) begin
            report_mismatch("result transfer with nothing expected");
            return;
        end
        e = expected_q.pop_front();
        check_field("response_valid", got.response_valid, e.response_valid);
        check_field("response_byte", got.response_byte, e.response_byte);
        check_field("cell_data", got.cell_data, e.cell_data);
        check_field("cursor_col", got.cursor_col, e.cursor_col);
        check_field("cursor_row", got.cursor_row, e.cursor_row);
        check_field("view_top", got.view_top, e.view_top);
        check_field("last", got.last, e.last);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_errors = 0;
            reset_terminal();
        end else begin
            if (i_cfg_valid && i_cfg_ready) blank = i_cfg_data;
            if (i_out_valid && i_out_ready) compare(i_out_data);
            if (i_in_valid && i_in_ready) predict(i_in_data);
        end
    end

endmodule

[bench/ansi_text_terminal_buffer_test.sv]
// ----------------------------------------------------------------------------
// ansi_text_terminal_buffer_test
// Drives the terminal buffer with directed characters, escape sequences and
// cell reads, then random well-formed and broken sequences over four runs
// at three idling settings and several blank colours. A checker beside the block
// predicts and compares every result; this module reports the verdict.
// ----------------------------------------------------------------------------
module ansi_text_terminal_buffer_test;
    import atb_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   send_idle;
    int   recv_idle;
    int   sent;
    int   pending;
    int   errors;

    atb_stream_if #(.T_DATA(t_in_item))   in_if ();
    atb_stream_if #(.T_DATA(t_out_item))  out_if ();
    atb_stream_if #(.T_DATA(logic [7:0])) cfg_if ();

    ansi_text_terminal_buffer i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    atb_terminal_checker i_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_if.valid),
        .i_in_ready  (in_if.ready),
        .i_in_data   (in_if.data),
        .i_out_valid (out_if.valid),
        .i_out_ready (out_if.ready),
        .i_out_data  (out_if.data),
        .i_cfg_valid (cfg_if.valid),
        .i_cfg_ready (cfg_if.ready),
        .i_cfg_data  (cfg_if.data),
        .o_pending   (pending),
        .o_errors    (errors)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) out_if.ready <= ($urandom_range(99) >= recv_idle);

    initial begin
        #200000000;
        $display("Some tests failed");
        $finish;
    end

    task automatic send(t_in_item it);
        in_if.data  <= it;
        in_if.valid <= 1'b1;
        do @(posedge i_clk); while (!in_if.ready);
        sent++;
        if ($urandom_range(99) < send_idle) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic put(logic [7:0] c, logic [7:0] a);
        t_in_item it;
        it.op = OP_PUT;
        it.char_code = c;
        it.color = a;
        it.cell_address = 14'($urandom_range(16383));
        send(it);
    endtask

    task automatic read_cell(logic [13:0] addr);
        t_in_item it;
        it.op = OP_READ;
        it.char_code = 8'($urandom_range(255));
        it.color = 8'($urandom_range(255));
        it.cell_address = addr;
        send(it);
    endtask

    function automatic logic [7:0] pick_color();
        return $urandom_range(1) ? 8'd0 : 8'($urandom_range(255));
    endfunction

    task automatic put_number(int unsigned v, logic [7:0] a);
        string s;
        int i;
        s = $sformatf("%0d", v);
        for (i = 0; i < s.len(); i++) put(s[i], a);
    endtask

    task automatic send_csi();
        logic [7:0] fin_byte, a;
        int r, np, k;
        int unsigned v;
        a = pick_color();
        r = $urandom_range(99);
        if (r < 25) fin_byte = FB_SGR;
        else if (r < 33) fin_byte = FB_CUP;
        else if (r < 40) fin_byte = FB_HVP;
        else if (r < 50) fin_byte = FB_CUU;
        else if (r < 60) fin_byte = FB_CUD;
        else if (r < 67) fin_byte = FB_CUF;
        else if (r < 74) fin_byte = FB_CUB;
        else if (r < 77) fin_byte = FB_ED;
        else if (r < 84) fin_byte = FB_EL;
        else if (r < 94) fin_byte = FB_DSR;
        else fin_byte = 8'($urandom_range(255));
        np = ($urandom_range(9) == 0) ? $urandom_range(3, 10) : $urandom_range(0, 2);
        if (fin_byte == FB_DSR && np == 0) np = 1;
        put(CH_ESC, a);
        put(CH_LBRACK, a);
        if ($urandom_range(9) == 0) put(CH_QMARK, a);
        for (k = 0; k < np; k++) begin
            if (k > 0) put(CH_SEMI, a);
            if ($urandom_range(19) == 0) begin
                v = $urandom_range(65530, 99999);
            end else begin
                case (fin_byte)
                    FB_SGR: begin
                        case ($urandom_range(5))
                            0: v = 0;
                            1: v = 30 + $urandom_range(7);
                            2: v = 40 + $urandom_range(7);
                            3: v = 90 + $urandom_range(7);
                            4: v = 100 + $urandom_range(7);
                            default: v = $urandom_range(120);
                        endcase
                    end
                    FB_CUP, FB_HVP: v = (k == 0) ? $urandom_range(1, 25) : $urandom_range(80);
                    FB_DSR: v = ($urandom_range(4) != 0) ? 6 : $urandom_range(9);
                    FB_ED: v = (k == 0 && $urandom_range(3) == 0) ? 2 : $urandom_range(3);
                    default: v = $urandom_range(30);
                endcase
            end
            put_number(v, a);
        end
        put(fin_byte, a);
    endtask

    task automatic random_step();
        int r;
        r = $urandom_range(99);
        if (r < 35) put(8'($urandom_range(32, 255)), pick_color());
        else if (r < 45) put(8'($urandom_range(31)), pick_color());
        else if (r < 70) send_csi();
        else if (r < 73) begin
            put(CH_ESC, pick_color());
            put(8'($urandom_range(255)), pick_color());
        end else if (r < 75) put(8'($urandom_range(255)), pick_color());
        else if (r < 88) read_cell(14'($urandom_range(10239)));
        else read_cell(14'($urandom_range(16383)));
    endtask

    task automatic drain();
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_blank(logic [7:0] v);
        drain();
        cfg_if.data  <= v;
        cfg_if.valid <= 1'b1;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic run_random(int sidle, int ridle, int count);
        int target;
        send_idle = sidle;
        recv_idle = ridle;
        target = sent + count;
        while (sent < target) random_step();
    endtask

    initial begin
        send_idle = 26;
        recv_idle = 64;
        sent = 0;
        i_rst_n      <= 1'b0;
        in_if.valid  <= 1'b0;
        in_if.data   <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.data  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        put(8'h41, 8'd0);
        put(8'hFF, 8'hFF);
        put(8'h01, 8'h80);
        put(CH_CR, 8'd0);
        put(CH_TAB, 8'd0);
        put(CH_BS, 8'd0);
        put(CH_NL, 8'd0);
        read_cell(14'd0);
        read_cell(14'd10239);
        read_cell(14'd10240);
        read_cell(14'd16383);
        put(CH_ESC, 8'd0);
        put(CH_LBRACK, 8'd0);
        put(8'h36, 8'd0);
        put(FB_DSR, 8'd0);
        put(CH_ESC, 8'd0);
        put(8'h78, 8'd0);
        put(CH_ESC, 8'd0);
        put(CH_LBRACK, 8'd0);
        put(CH_QMARK, 8'd0);
        put(8'h32, 8'd0);
        put(FB_ED, 8'd0);

        in_if.valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);

        run_random(26, 64, 110);
        in_if.valid <= 1'b0;
        write_blank(8'hFF);
        run_random(64, 26, 120);
        in_if.valid <= 1'b0;
        write_blank(8'h00);
        run_random(0, 0, 55);
        in_if.valid <= 1'b0;
        write_blank(8'($urandom_range(1, 254)));
        run_random(0, 0, 55);
        in_if.valid <= 1'b0;

        drain();
        if (errors == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end

endmodule

[files.f]
sv/atb_pkg.sv
sv/atb_stream_if.sv
sv/atb_cell_ram.sv
sv/atb_ctrl.sv
sv/ansi_text_terminal_buffer.sv
bench/atb_terminal_checker.sv
bench/ansi_text_terminal_buffer_test.sv
